[sv/jjy_time_code_transmitter_assert.svh]
// ----------------------------------------------------------------------------
// JJY time code transmitter assertion macros
// Concurrent assertion wrappers; empty bodies when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef JJY_TIME_CODE_TRANSMITTER_ASSERT_SVH
`define JJY_TIME_CODE_TRANSMITTER_ASSERT_SVH

`ifndef SYNTHESIS

// property that must hold at every clock edge out of reset
`define JJY_ASSERT_HOLD(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("jjy assertion failed");

// antecedent in one cycle implies consequent in the next
`define JJY_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("jjy assertion failed");

`else

`define JJY_ASSERT_HOLD(label, clk, rst_n, prop)
`define JJY_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[sv/jjy_pkg.sv]
// ----------------------------------------------------------------------------
// JJY package
// Shared constants, symbol codes, control structs and BCD helper functions.
// ----------------------------------------------------------------------------
package jjy_pkg;

    // frame geometry
    localparam int SLOT_COUNT = 60;
    localparam int SLOT_W     = 6;
    localparam int MS_W       = 10;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOT_COUNT - 1);

    // symbol codes
    localparam logic [1:0] SYM_ZERO = 2'd0;
    localparam logic [1:0] SYM_ONE  = 2'd1;
    localparam logic [1:0] SYM_MARK = 2'd2;

    // input operation codes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // configuration register indexes
    localparam logic [1:0] REG_MARKER_HIGH = 2'd0;
    localparam logic [1:0] REG_ONE_HIGH    = 2'd1;
    localparam logic [1:0] REG_ZERO_HIGH   = 2'd2;
    localparam logic [1:0] REG_SECOND_LEN  = 2'd3;

    // configuration reset values
    localparam logic [MS_W-1:0] MARKER_HIGH_RST = MS_W'(200);
    localparam logic [MS_W-1:0] ONE_HIGH_RST    = MS_W'(500);
    localparam logic [MS_W-1:0] ZERO_HIGH_RST   = MS_W'(800);
    localparam logic [MS_W-1:0] SECOND_LEN_RST  = MS_W'(1000);

    // control of one symbol cell
    typedef struct packed {
        logic load;
        logic shift;
    } cell_ctl_t;

    // one result beat
    typedef struct packed {
        logic              carrier_on;
        logic [SLOT_W-1:0] second_index;
        logic [1:0]        symbol_kind;
        logic              frame_done;
        logic              busy_res;
    } res_t;

    // quotient by ten through reciprocal multiply, exact for x below 1029
    function automatic logic [5:0] div10(input logic [8:0] x);
        logic [16:0] p;
        p = 17'(x) * 17'd205;
        return p[16:11];
    endfunction

    // remainder by ten given the quotient
    function automatic logic [3:0] rem10(input logic [8:0] x, input logic [5:0] q);
        logic [8:0] r;
        r = x - 9'(q) * 9'd10;
        return r[3:0];
    endfunction

    // quotient by one hundred, exact for x below 1000
    function automatic logic [2:0] div100(input logic [8:0] x);
        logic [14:0] p;
        p = 15'(x) * 15'd41;
        return p[14:12];
    endfunction

endpackage

[sv/jjy_sym_cell.sv]
// ----------------------------------------------------------------------------
// JJY symbol cell
// Holds one frame symbol; loads from the frame builder or takes its
// neighbor's symbol when the frame advances one slot.
// ----------------------------------------------------------------------------
module jjy_sym_cell
    import jjy_pkg::*;
(
    input  logic       clk,
    input  cell_ctl_t  ctl,
    input  logic [1:0] load_sym,
    input  logic [1:0] next_sym,
    output logic [1:0] sym
);

    logic [1:0] sym_reg;
    logic [1:0] sym_next;

    // load wins over shift
    always_comb
    begin
        sym_next = sym_reg;
        if (ctl.load)
        begin
            sym_next = load_sym;
        end
        else if (ctl.shift)
        begin
            sym_next = next_sym;
        end
    end

    always_ff @(posedge clk)
    begin
        sym_reg <= sym_next;
    end

    assign sym = sym_reg;

endmodule

[sv/jjy_frame_builder.sv]
// ----------------------------------------------------------------------------
// JJY frame builder
// Converts the binary time fields to BCD and lays out the 60 slot symbols.
// ----------------------------------------------------------------------------
module jjy_frame_builder
    import jjy_pkg::*;
(
    input  logic [5:0]                  minute_value,
    input  logic [4:0]                  hour_value,
    input  logic [8:0]                  day_of_year,
    input  logic [6:0]                  year_two_digits,
    input  logic [2:0]                  weekday_value,
    output logic [SLOT_COUNT-1:0][1:0]  frame
);

    logic [5:0] mn_t;
    logic [3:0] mn_u;
    logic [5:0] hr_t;
    logic [3:0] hr_u;
    logic [2:0] dy_h;
    logic [5:0] dy_q;
    logic [5:0] dy_qq;
    logic [3:0] dy_t;
    logic [3:0] dy_u;
    logic [5:0] yr_t;
    logic [3:0] yr_u;
    logic       hr_par;
    logic       mn_par;

    // digit split
    always_comb
    begin
        mn_t  = div10(9'(minute_value));
        mn_u  = rem10(9'(minute_value), mn_t);
        hr_t  = div10(9'(hour_value));
        hr_u  = rem10(9'(hour_value), hr_t);
        dy_h  = div100(day_of_year);
        dy_q  = div10(day_of_year);
        dy_u  = rem10(day_of_year, dy_q);
        dy_qq = div10(9'(dy_q));
        dy_t  = rem10(9'(dy_q), dy_qq);
        yr_t  = div10(9'(year_two_digits));
        yr_u  = rem10(9'(year_two_digits), yr_t);
        hr_par = ^{hr_t[1:0], hr_u};
        mn_par = ^{mn_t[2:0], mn_u};
    end

    // slot layout, unused slots stay binary zero
    always_comb
    begin
        frame = '0;
        frame[0]  = SYM_MARK;
        frame[9]  = SYM_MARK;
        frame[19] = SYM_MARK;
        frame[29] = SYM_MARK;
        frame[39] = SYM_MARK;
        frame[49] = SYM_MARK;
        frame[59] = SYM_MARK;
        // minute
        frame[1] = {1'b0, mn_t[2]};
        frame[2] = {1'b0, mn_t[1]};
        frame[3] = {1'b0, mn_t[0]};
        frame[5] = {1'b0, mn_u[3]};
        frame[6] = {1'b0, mn_u[2]};
        frame[7] = {1'b0, mn_u[1]};
        frame[8] = {1'b0, mn_u[0]};
        // hour
        frame[12] = {1'b0, hr_t[1]};
        frame[13] = {1'b0, hr_t[0]};
        frame[15] = {1'b0, hr_u[3]};
        frame[16] = {1'b0, hr_u[2]};
        frame[17] = {1'b0, hr_u[1]};
        frame[18] = {1'b0, hr_u[0]};
        // day of year
        frame[22] = {1'b0, dy_h[1]};
        frame[23] = {1'b0, dy_h[0]};
        frame[25] = {1'b0, dy_t[3]};
        frame[26] = {1'b0, dy_t[2]};
        frame[27] = {1'b0, dy_t[1]};
        frame[28] = {1'b0, dy_t[0]};
        frame[30] = {1'b0, dy_u[3]};
        frame[31] = {1'b0, dy_u[2]};
        frame[32] = {1'b0, dy_u[1]};
        frame[33] = {1'b0, dy_u[0]};
        // parity
        frame[36] = {1'b0, hr_par};
        frame[37] = {1'b0, mn_par};
        // year
        frame[41] = {1'b0, yr_t[3]};
        frame[42] = {1'b0, yr_t[2]};
        frame[43] = {1'b0, yr_t[1]};
        frame[44] = {1'b0, yr_t[0]};
        frame[45] = {1'b0, yr_u[3]};
        frame[46] = {1'b0, yr_u[2]};
        frame[47] = {1'b0, yr_u[1]};
        frame[48] = {1'b0, yr_u[0]};
        // weekday
        frame[50] = {1'b0, weekday_value[2]};
        frame[51] = {1'b0, weekday_value[1]};
        frame[52] = {1'b0, weekday_value[0]};
    end

endmodule

[sv/jjy_time_code_transmitter.sv]
// ----------------------------------------------------------------------------
// JJY time code transmitter
// Builds the JJY minute frame on load and gives the carrier keying envelope
// one tick beat at a time.
//
//   channel   direction   handshake              payload
//   input     in          in_valid / in_stall    op and time fields
//   output    out         out_valid / out_stall  envelope and slot status
//   config    in          cfg_wr_en              cfg_index, cfg_data
//
// One beat is accepted per cycle while in_stall is low; the accepting edge
// loads its result into the output register, which offers it from the
// next cycle on, or, while the output is stalled, into a skid register of
// one entry; in_stall is high only while it is full. The slot symbols sit
// in a rotating chain of 60 cells and the current slot is always read
// from cell 0, so a tick costs one counter compare. Reset puts the block
// idle with default timing registers; the symbol cells are not cleared.
// ----------------------------------------------------------------------------
`include "jjy_time_code_transmitter_assert.svh"

module jjy_time_code_transmitter
    import jjy_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    // input channel
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              op,
    input  logic [5:0]        minute_value,
    input  logic [4:0]        hour_value,
    input  logic [8:0]        day_of_year,
    input  logic [6:0]        year_two_digits,
    input  logic [2:0]        weekday_value,
    // output channel
    output logic              out_valid,
    input  logic              out_stall,
    output logic              carrier_on,
    output logic [SLOT_W-1:0] second_index,
    output logic [1:0]        symbol_kind,
    output logic              frame_done,
    output logic              busy_res,
    // configuration
    input  logic              cfg_wr_en,
    input  logic [1:0]        cfg_index,
    input  logic [MS_W-1:0]   cfg_data
);

    logic [SLOT_COUNT-1:0][1:0] build_frame;
    logic [1:0]                 cell_sym [SLOT_COUNT];
    cell_ctl_t                  cell_ctl;

    logic [MS_W-1:0]   marker_high_reg;
    logic [MS_W-1:0]   one_high_reg;
    logic [MS_W-1:0]   zero_high_reg;
    logic [MS_W-1:0]   second_len_reg;

    logic [SLOT_W-1:0] slot_reg;
    logic [SLOT_W-1:0] slot_next;
    logic [MS_W-1:0]   tick_reg;
    logic [MS_W-1:0]   tick_next;
    logic              sending_reg;
    logic              sending_next;

    res_t              out_reg;
    res_t              out_next;
    res_t              skid_reg;
    res_t              skid_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              skid_valid_reg;
    logic              skid_valid_next;

    logic              in_acc;
    logic              out_fire;
    logic [1:0]        cur_sym;
    logic [MS_W-1:0]   high_ms;
    logic [MS_W-1:0]   len_m1;
    logic              slot_last;
    logic              frame_last;
    res_t              res_c;

    assign in_stall = skid_valid_reg;
    assign in_acc   = in_valid & ~skid_valid_reg;
    assign out_fire = out_valid_reg & ~out_stall;

    // frame layout from the time fields
    jjy_frame_builder u_builder (
        .minute_value    (minute_value),
        .hour_value      (hour_value),
        .day_of_year     (day_of_year),
        .year_two_digits (year_two_digits),
        .weekday_value   (weekday_value),
        .frame           (build_frame)
    );

    // rotating chain of symbol cells, cell 0 holds the current slot
    genvar gi;
    generate
        for (gi = 0; gi < SLOT_COUNT; gi++)
        begin : g_cell
            jjy_sym_cell u_cell (
                .clk      (clk),
                .ctl      (cell_ctl),
                .load_sym (build_frame[gi]),
                .next_sym (cell_sym[(gi + 1) % SLOT_COUNT]),
                .sym      (cell_sym[gi])
            );
        end
    endgenerate

    assign cur_sym = cell_sym[0];

    // per-tick envelope decision
    always_comb
    begin
        case (cur_sym)
            SYM_MARK: high_ms = marker_high_reg;
            SYM_ONE:  high_ms = one_high_reg;
            default:  high_ms = zero_high_reg;
        endcase
        len_m1     = (second_len_reg == '0) ? '0 : second_len_reg - MS_W'(1);
        slot_last  = tick_reg >= len_m1;
        frame_last = slot_last && (slot_reg == LAST_SLOT);
    end

    // result of the beat and next counter state
    always_comb
    begin
        res_c        = '0;
        slot_next    = slot_reg;
        tick_next    = tick_reg;
        sending_next = sending_reg;
        cell_ctl     = '0;
        if (in_acc)
        begin
            if (op == OP_LOAD)
            begin
                res_c.symbol_kind = SYM_MARK;
                res_c.busy_res    = 1'b1;
                slot_next         = '0;
                tick_next         = '0;
                sending_next      = 1'b1;
                cell_ctl.load     = 1'b1;
            end
            else if (sending_reg)
            begin
                res_c.carrier_on   = tick_reg < high_ms;
                res_c.second_index = slot_reg;
                res_c.symbol_kind  = cur_sym;
                res_c.frame_done   = frame_last;
                res_c.busy_res     = 1'b1;
                if (slot_last)
                begin
                    tick_next      = '0;
                    cell_ctl.shift = 1'b1;
                    if (frame_last)
                    begin
                        slot_next    = '0;
                        sending_next = 1'b0;
                    end
                    else
                    begin
                        slot_next = slot_reg + SLOT_W'(1);
                    end
                end
                else
                begin
                    tick_next = tick_reg + MS_W'(1);
                end
            end
        end
    end

    // output register with one skid entry
    always_comb
    begin
        out_next        = out_reg;
        skid_next       = skid_reg;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (in_acc)
        begin
            if (!out_valid_reg || out_fire)
            begin
                out_next       = res_c;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = res_c;
                skid_valid_next = 1'b1;
            end
        end
        else if (out_fire)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg        <= '0;
            tick_reg        <= '0;
            sending_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
            skid_valid_reg  <= 1'b0;
            marker_high_reg <= MARKER_HIGH_RST;
            one_high_reg    <= ONE_HIGH_RST;
            zero_high_reg   <= ZERO_HIGH_RST;
            second_len_reg  <= SECOND_LEN_RST;
        end
        else
        begin
            slot_reg       <= slot_next;
            tick_reg       <= tick_next;
            sending_reg    <= sending_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    REG_MARKER_HIGH: marker_high_reg <= cfg_data;
                    REG_ONE_HIGH:    one_high_reg    <= cfg_data;
                    REG_ZERO_HIGH:   zero_high_reg   <= cfg_data;
                    REG_SECOND_LEN:  second_len_reg  <= cfg_data;
                    default:         second_len_reg  <= second_len_reg;
                endcase
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign out_valid    = out_valid_reg;
    assign carrier_on   = out_reg.carrier_on;
    assign second_index = out_reg.second_index;
    assign symbol_kind  = out_reg.symbol_kind;
    assign frame_done   = out_reg.frame_done;
    assign busy_res     = out_reg.busy_res;

    // checks
    `JJY_ASSERT_HOLD(a_skid_needs_out, clk, rst_n, !skid_valid_reg || out_valid_reg)
    `JJY_ASSERT_HOLD(a_slot_in_frame, clk, rst_n, slot_reg <= LAST_SLOT)
    `JJY_ASSERT_HOLD(a_done_on_last_slot, clk, rst_n,
        !(out_valid_reg && out_reg.frame_done) ||
        (out_reg.second_index == LAST_SLOT && out_reg.busy_res))
    `JJY_ASSERT_NEXT(a_idle_after_frame, clk, rst_n,
        in_acc && op == OP_TICK && sending_reg && frame_last,
        !sending_reg && slot_reg == '0)
    `JJY_ASSERT_NEXT(a_load_starts_frame, clk, rst_n, in_acc && op == OP_LOAD,
        sending_reg && slot_reg == '0 && tick_reg == '0 && cur_sym == SYM_MARK)

endmodule

[verif/jjy_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JJY time code transmitter checker
// Watches the input, output and register write ports of the transmitter.
// It keeps its own copy of the frame symbols, slot and tick counters and
// timing registers, predicts the envelope beat for every accepted input beat,
// and compares each accepted output beat field by field, oldest first.
// ----------------------------------------------------------------------------
module jjy_checker
    import jjy_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_stall,
    input  logic              op,
    input  logic [5:0]        minute_value,
    input  logic [4:0]        hour_value,
    input  logic [8:0]        day_of_year,
    input  logic [6:0]        year_two_digits,
    input  logic [2:0]        weekday_value,
    input  logic              out_valid,
    input  logic              out_stall,
    input  logic              carrier_on,
    input  logic [SLOT_W-1:0] second_index,
    input  logic [1:0]        symbol_kind,
    input  logic              frame_done,
    input  logic              busy_res,
    input  logic              cfg_wr_en,
    input  logic [1:0]        cfg_index,
    input  logic [MS_W-1:0]   cfg_data,
    output int                fail_count,
    output int                pending_count
);

    // local copy of the frame and its counters
    logic [1:0]        code_slots [SLOT_COUNT];
    logic [SLOT_W-1:0] slot_pos;
    logic [MS_W-1:0]   tick_pos;
    logic              frame_active;

    // local copy of the timing registers
    logic [MS_W-1:0]   marker_on_ms;
    logic [MS_W-1:0]   one_on_ms;
    logic [MS_W-1:0]   zero_on_ms;
    logic [MS_W-1:0]   slot_len_ms;

    // envelope beats still owed by the block
    res_t              envelope_q [$];
    res_t              seen_beat;
    res_t              owed_beat;
    res_t              next_beat;

    // one BCD bit as a binary symbol
    function automatic logic [1:0] bit_sym(input int unsigned v, input int b);
        return ((v >> b) & 1) != 0 ? SYM_ONE : SYM_ZERO;
    endfunction

    // build the 60 slot time code from binary time fields
    task automatic encode_time(input int unsigned mn, hr, dy, yr, wd);
        int unsigned tens;
        int unsigned units;
        int unsigned hundreds;
        logic        par;
        for (int i = 0; i < SLOT_COUNT; i++)
            code_slots[i] = SYM_ZERO;
        code_slots[0]  = SYM_MARK;
        code_slots[9]  = SYM_MARK;
        code_slots[19] = SYM_MARK;
        code_slots[29] = SYM_MARK;
        code_slots[39] = SYM_MARK;
        code_slots[49] = SYM_MARK;
        code_slots[59] = SYM_MARK;

        // minute
        tens = mn / 10;
        units = mn % 10;
        code_slots[1] = bit_sym(tens, 2);
        code_slots[2] = bit_sym(tens, 1);
        code_slots[3] = bit_sym(tens, 0);
        for (int b = 0; b < 4; b++)
            code_slots[8 - b] = bit_sym(units, b);

        // hour
        tens = hr / 10;
        units = hr % 10;
        code_slots[12] = bit_sym(tens, 1);
        code_slots[13] = bit_sym(tens, 0);
        for (int b = 0; b < 4; b++)
            code_slots[18 - b] = bit_sym(units, b);

        // day of year
        hundreds = dy / 100;
        tens = (dy / 10) % 10;
        units = dy % 10;
        code_slots[22] = bit_sym(hundreds, 1);
        code_slots[23] = bit_sym(hundreds, 0);
        for (int b = 0; b < 4; b++)
        begin
            code_slots[28 - b] = bit_sym(tens, b);
            code_slots[33 - b] = bit_sym(units, b);
        end

        // even parity over hour bits, then minute bits
        par = 1'b0;
        for (int i = 12; i <= 18; i++)
            par ^= (code_slots[i] == SYM_ONE);
        code_slots[36] = par ? SYM_ONE : SYM_ZERO;
        par = 1'b0;
        for (int i = 1; i <= 8; i++)
            par ^= (code_slots[i] == SYM_ONE);
        code_slots[37] = par ? SYM_ONE : SYM_ZERO;

        // year and weekday
        tens = yr / 10;
        units = yr % 10;
        for (int b = 0; b < 4; b++)
        begin
            code_slots[44 - b] = bit_sym(tens, b);
            code_slots[48 - b] = bit_sym(units, b);
        end
        for (int b = 0; b < 3; b++)
            code_slots[52 - b] = bit_sym(wd, b);
    endtask

    // envelope beat for one input beat, advancing the frame position
    task automatic next_envelope(input logic b_op, input int unsigned mn, hr, dy, yr, wd,
                                 output res_t r);
        logic [1:0]      kind;
        logic [MS_W-1:0] on_ms;
        logic [MS_W-1:0] len;
        logic            last;
        r = '0;
        if (b_op == OP_LOAD)
        begin
            encode_time(mn, hr, dy, yr, wd);
            slot_pos = '0;
            tick_pos = '0;
            frame_active = 1'b1;
            r.symbol_kind = SYM_MARK;
            r.busy_res = 1'b1;
        end
        else if (frame_active)
        begin
            kind = code_slots[slot_pos];
            case (kind)
                SYM_MARK: on_ms = marker_on_ms;
                SYM_ONE:  on_ms = one_on_ms;
                default:  on_ms = zero_on_ms;
            endcase
            // a zero slot length counts as one tick
            len = (slot_len_ms == '0) ? MS_W'(1) : slot_len_ms;
            last = (tick_pos >= len - 1'b1);
            r.carrier_on = (tick_pos < on_ms);
            r.second_index = slot_pos;
            r.symbol_kind = kind;
            r.frame_done = last && (slot_pos == LAST_SLOT);
            r.busy_res = 1'b1;
            if (last)
            begin
                tick_pos = '0;
                if (slot_pos == LAST_SLOT)
                begin
                    slot_pos = '0;
                    frame_active = 1'b0;
                end
                else
                    slot_pos = slot_pos + 1'b1;
            end
            else
                tick_pos = tick_pos + 1'b1;
        end
    endtask

    task automatic check_field(input string name, input logic [9:0] want, got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    // register writes, output compare, then prediction of the new beat
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOT_COUNT; i++)
                code_slots[i] = SYM_ZERO;
            slot_pos = '0;
            tick_pos = '0;
            frame_active = 1'b0;
            marker_on_ms = MARKER_HIGH_RST;
            one_on_ms = ONE_HIGH_RST;
            zero_on_ms = ZERO_HIGH_RST;
            slot_len_ms = SECOND_LEN_RST;
            envelope_q.delete();
            fail_count = 0;
            pending_count = 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_MARKER_HIGH: marker_on_ms = cfg_data;
                    REG_ONE_HIGH:    one_on_ms = cfg_data;
                    REG_ZERO_HIGH:   zero_on_ms = cfg_data;
                    REG_SECOND_LEN:  slot_len_ms = cfg_data;
                    default:         ;
                endcase
            end

            if (out_valid && !out_stall)
            begin
                seen_beat = {carrier_on, second_index, symbol_kind, frame_done, busy_res};
                if (envelope_q.size() == 0)
                begin
                    $display("%0t: unexpected beat: expected none, got %h", $time, seen_beat);
                    fail_count++;
                end
                else
                begin
                    owed_beat = envelope_q.pop_front();
                    check_field("carrier_on", owed_beat.carrier_on, seen_beat.carrier_on);
                    check_field("second_index", owed_beat.second_index,
                                seen_beat.second_index);
                    check_field("symbol_kind", owed_beat.symbol_kind, seen_beat.symbol_kind);
                    check_field("frame_done", owed_beat.frame_done, seen_beat.frame_done);
                    check_field("busy_res", owed_beat.busy_res, seen_beat.busy_res);
                end
            end

            if (in_valid && !in_stall)
            begin
                next_envelope(op, minute_value, hour_value, day_of_year, year_two_digits,
                              weekday_value, next_beat);
                envelope_q.push_back(next_beat);
            end
            pending_count = envelope_q.size();
        end
    end

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JJY time code transmitter testbench
// Drives load and tick beats into the transmitter under several timing
// register settings and idle patterns; a checker beside the block predicts
// and compares every envelope beat, and this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
    import jjy_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic              op;
    logic [5:0]        minute_value;
    logic [4:0]        hour_value;
    logic [8:0]        day_of_year;
    logic [6:0]        year_two_digits;
    logic [2:0]        weekday_value;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic              carrier_on;
    logic [SLOT_W-1:0] second_index;
    logic [1:0]        symbol_kind;
    logic              frame_done;
    logic              busy_res;
    logic              cfg_wr_en;
    logic [1:0]        cfg_index;
    logic [MS_W-1:0]   cfg_data;

    int                fail_count;
    int                pending_count;
    int                cycle_count = 0;
    int                send_idle_pct = 0;
    int                recv_stall_pct = 0;

    always #2 clk = ~clk;

    // receiver stalls at random
    always @(negedge clk)
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);

    jjy_time_code_transmitter DUT (.*);

    jjy_checker u_checker (.*);

    // run limit
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("** jjy_time_code_transmitter: FAILED **");
        $finish;
    end

    // one input beat, held until accepted; called and returns at a falling edge
    task automatic send_beat(input logic b_op, input logic [5:0] mn, input logic [4:0] hr,
                             input logic [8:0] dy, input logic [6:0] yr,
                             input logic [2:0] wd);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        op <= b_op;
        minute_value <= mn;
        hour_value <= hr;
        day_of_year <= dy;
        year_two_digits <= yr;
        weekday_value <= wd;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    // tick with junk on the time fields
    task automatic send_tick();
        send_beat(OP_TICK, 6'($urandom), 5'($urandom), 9'($urandom), 7'($urandom),
                  3'($urandom));
    endtask

    // load, mostly in range, sometimes any value the fields hold
    task automatic send_random_load();
        if ($urandom_range(0, 3) == 0)
            send_beat(OP_LOAD, 6'($urandom), 5'($urandom), 9'($urandom), 7'($urandom),
                      3'($urandom));
        else
            send_beat(OP_LOAD, 6'($urandom_range(0, 59)), 5'($urandom_range(0, 23)),
                      9'($urandom_range(1, 366)), 7'($urandom_range(0, 99)),
                      3'($urandom_range(0, 6)));
    endtask

    task automatic set_timing(input logic [MS_W-1:0] m, o, z, l);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_MARKER_HIGH;
        cfg_data <= m;
        @(negedge clk);
        cfg_index <= REG_ONE_HIGH;
        cfg_data <= o;
        @(negedge clk);
        cfg_index <= REG_ZERO_HIGH;
        cfg_data <= z;
        @(negedge clk);
        cfg_index <= REG_SECOND_LEN;
        cfg_data <= l;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
    endtask

    // wait until every owed beat has come out
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_count != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    initial
    begin
        int              n;
        int              budget;
        int              ticks;
        int              r;
        int              len_eff;
        logic [MS_W-1:0] m, o, z, l;

        rst_n = 1'b0;
        in_valid = 1'b0;
        op = OP_TICK;
        minute_value = '0;
        hour_value = '0;
        day_of_year = '0;
        year_two_digits = '0;
        weekday_value = '0;
        cfg_wr_en = 1'b0;
        cfg_index = REG_MARKER_HIGH;
        cfg_data = '0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        // directed: idle tick, loads at the field extremes, load while sending
        send_tick();
        send_beat(OP_LOAD, 6'd63, 5'd31, 9'd511, 7'd127, 3'd7);
        repeat (3) send_tick();
        send_beat(OP_LOAD, 6'd0, 5'd0, 9'd0, 7'd0, 3'd0);
        repeat (2) send_tick();
        send_beat(OP_LOAD, 6'd59, 5'd23, 9'd366, 7'd99, 3'd6);
        repeat (2) send_tick();
        send_beat(OP_LOAD, 6'd0, 5'd0, 9'd1, 7'd0, 3'd0);
        send_tick();

        // random phases over timing settings and idle patterns
        for (int ph = 0; ph < 8; ph++)
        begin
            drain();
            case (ph)
                0: begin m = 10'd1023; o = 10'd0;    z = 10'd1;    l = 10'd0;    end
                1: begin m = 10'd2;    o = 10'd1;    z = 10'd0;    l = 10'd3;    end
                2: begin m = 10'd0;    o = 10'd3;    z = 10'd2;    l = 10'd2;    end
                4: begin m = 10'd1023; o = 10'd1023; z = 10'd1023; l = 10'd1;    end
                5: begin m = 10'd0;    o = 10'd0;    z = 10'd0;    l = 10'd4;    end
                6: begin m = 10'd5;    o = 10'd1;    z = 10'd3;    l = 10'd1023; end
                default:
                begin
                    m = 10'($urandom_range(0, 4));
                    o = 10'($urandom_range(0, 4));
                    z = 10'($urandom_range(0, 4));
                    l = 10'($urandom_range(1, 4));
                end
            endcase
            set_timing(m, o, z, l);
            len_eff = (l == '0) ? 1 : int'(l);

            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
                default: begin send_idle_pct = 17; recv_stall_pct = 17; end
            endcase
            // a full frame alone overshoots a short budget, so keep it small
            budget = (len_eff > 8) ? 40 : 24;

            // first carry on with any frame left running, possibly mid-slot
            n = $urandom_range(1, 3);
            repeat (n) send_tick();
            while (n < budget)
            begin
                r = $urandom_range(0, 99);
                if (len_eff > 8)
                    ticks = $urandom_range(5, 40);
                else if (r < 75)
                    ticks = SLOT_COUNT * len_eff + $urandom_range(0, 3);
                else
                    ticks = $urandom_range(0, SLOT_COUNT * len_eff);
                // mostly full frames, some cut short, some bare ticks; with long slots only part of a frame
                if (r < 92)
                begin
                    send_random_load();
                    n++;
                end
                repeat (ticks) send_tick();
                n += ticks;
            end
        end

        drain();
        if (fail_count == 0 && pending_count == 0)
            $display("** jjy_time_code_transmitter: PASSED **");
        else
            $display("** jjy_time_code_transmitter: FAILED **");
        $finish;
    end

endmodule
